// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define SFCRC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sfcrc assertion failed");

// consequent holds in the cycle after the antecedent
`define SFCRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfcrc assertion failed");

`endif

// ===== src/sfcrc_pkg.sv =====
// shared constants and the crc byte update for the scope frame encoder
package sfcrc_pkg;

  localparam int INPUT_FIELDS = 4;
  localparam int CHAN_W = 16;
  localparam int POS_W = 4;
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  function automatic int used_channels(input int count);
    return (count < INPUT_FIELDS) ? count : INPUT_FIELDS;
  endfunction

  // one byte through the reflected crc, one bit per step
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/sfcrc_if.sv =====
// valid/ready channels for sample sets and frame bytes
interface sfcrc_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] channel_a;
  logic [15:0] channel_b;
  logic [15:0] channel_c;
  logic [15:0] channel_d;
  modport source (output valid, channel_a, channel_b, channel_c, channel_d, input ready);
  modport sink (input valid, channel_a, channel_b, channel_c, channel_d, output ready);
endinterface

interface sfcrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [3:0] byte_position;
  logic       frame_end;
  modport source (output valid, frame_byte, byte_position, frame_end, input ready);
  modport sink (input valid, frame_byte, byte_position, frame_end, output ready);
endinterface

// ===== src/scope_frame_crc16_encoder.sv =====
// top level of the scope frame encoder with crc-16/modbus trailer
//
// Takes one sample set (four 16-bit channel values) per input transfer and sends
// it as a frame of bytes: each framed channel low byte first, then a
// crc-16/modbus (preset 0xffff, reflected polynomial 0xa001, no final xor) over
// the data bytes, low byte first. The crc restarts with every frame. With
// CHANNEL_COUNT at its default of four a frame is ten bytes; in general it is
// 2*min(CHANNEL_COUNT, 4) + 2 bytes and unused channel inputs are ignored.
// Throughput is one frame byte per cycle while a set is queued and the output
// is ready. The back end loads a set's first byte into the output register
// when it starts on the set at the queue head, and pops the set with its last
// byte; with an empty queue and an idle output a set is first written into the
// queue and then its first byte into the output register. A two-entry queue
// sits between the front and back ends, so a new sample set can be taken while
// the current frame is still going out and the output may stall freely.
// frame_end marks the crc high byte. No memory, no clearing pass.
module scope_frame_crc16_encoder #(
  parameter int CHANNEL_COUNT = 4
) (
  input  logic          clk,
  input  logic          rst,
  sfcrc_sample_if.sink  sample,
  sfcrc_byte_if.source  frame
);

  localparam int USED = sfcrc_pkg::used_channels(CHANNEL_COUNT);
  localparam int W = sfcrc_pkg::CHAN_W * USED;

  // queue head between the two halves
  logic         q_valid;
  logic [W-1:0] q_data;
  logic         q_pop;

  // front: accepts sample sets and keeps the framed channels
  sfcrc_front #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  // back: walks the bytes, folds each data byte into the crc, sends the trailer
  sfcrc_back #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .frame   (frame)
  );

endmodule

// ===== src/sfcrc_front.sv =====
// front end: takes sample sets and holds them in a two-entry queue
module sfcrc_front #(
  parameter int CHANNEL_COUNT = 4
) (
  input  logic            clk,
  input  logic            rst,
  sfcrc_sample_if.sink    sample,
  output logic            q_valid,
  output logic [sfcrc_pkg::CHAN_W*sfcrc_pkg::used_channels(CHANNEL_COUNT)-1:0] q_data,
  input  logic            q_pop
);

  localparam int USED = sfcrc_pkg::used_channels(CHANNEL_COUNT);
  localparam int W = sfcrc_pkg::CHAN_W * USED;

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  logic [15:0]  chans [sfcrc_pkg::INPUT_FIELDS];
  logic [W-1:0] word;

  assign chans[0] = sample.channel_a;
  assign chans[1] = sample.channel_b;
  assign chans[2] = sample.channel_c;
  assign chans[3] = sample.channel_d;

  // pack the framed channels, first channel in the low bits
  always_comb begin
    for (int i = 0; i < USED; i++) begin
      word[i*sfcrc_pkg::CHAN_W +: sfcrc_pkg::CHAN_W] = chans[i];
    end
  end

  assign sample.ready = (count != 2'd2);
  assign push = sample.valid && sample.ready;
  assign q_valid = (count != 2'd0);
  assign q_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= word;
    end
  end

endmodule

// ===== src/sfcrc_back.sv =====
// back end: serializes the queue head into frame bytes and appends the crc
module sfcrc_back #(
  parameter int CHANNEL_COUNT = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  logic [sfcrc_pkg::CHAN_W*sfcrc_pkg::used_channels(CHANNEL_COUNT)-1:0] q_data,
  output logic            q_pop,
  sfcrc_byte_if.source    frame
);

  localparam int USED = sfcrc_pkg::used_channels(CHANNEL_COUNT);
  localparam int DATA_BYTES = 2 * USED;
  localparam int FRAME_BYTES = DATA_BYTES + 2;
  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam int DB_W = $clog2(DATA_BYTES);

  logic [7:0]       data_bytes [DATA_BYTES];
  logic [IDX_W-1:0] idx;
  logic [15:0]      crc;
  logic [15:0]      crc_next;
  logic             out_valid;
  logic             advance;
  logic             is_data;
  logic             is_last;
  logic [7:0]       next_byte;
  logic [7:0]       byte_reg;
  logic [3:0]       pos_reg;
  logic             end_reg;

  always_comb begin
    for (int i = 0; i < DATA_BYTES; i++) begin
      data_bytes[i] = q_data[i*8 +: 8];
    end
  end

  assign advance = q_valid && (!out_valid || frame.ready);
  assign is_data = idx < IDX_W'(DATA_BYTES);
  assign is_last = idx == IDX_W'(FRAME_BYTES - 1);
  assign q_pop = advance && is_last;

  always_comb begin
    if (is_data) begin
      next_byte = data_bytes[idx[DB_W-1:0]];
      crc_next = sfcrc_pkg::crc_update(crc, next_byte);
    end else if (is_last) begin
      next_byte = crc[15:8];
      crc_next = sfcrc_pkg::CRC_PRESET;
    end else begin
      next_byte = crc[7:0];
      crc_next = crc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      crc <= sfcrc_pkg::CRC_PRESET;
      out_valid <= 1'b0;
    end else if (advance) begin
      idx <= is_last ? '0 : idx + IDX_W'(1);
      crc <= crc_next;
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_reg <= next_byte;
      pos_reg <= sfcrc_pkg::POS_W'(idx);
      end_reg <= is_last;
    end
  end

  assign frame.valid = out_valid;
  assign frame.frame_byte = byte_reg;
  assign frame.byte_position = pos_reg;
  assign frame.frame_end = end_reg;

endmodule

// ===== src/sfcrc_checker.sv =====
// port-level checks on the frame output and their bind to the top level
`include "assert_macros.svh"

module sfcrc_checker #(
  parameter int CHANNEL_COUNT = 4
) (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] frame_byte,
  input logic [3:0] byte_position,
  input logic       frame_end
);

  localparam int LAST = 2 * sfcrc_pkg::used_channels(CHANNEL_COUNT) + 1;

  // stalled byte holds
  `SFCRC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(frame_byte) && $stable(byte_position) && $stable(frame_end))

  // frame end flags exactly the last position
  `SFCRC_ASSERT(a_end_pos, !out_valid || (frame_end == (byte_position == 4'(LAST))))

  // inside a frame bytes follow each other with no gap
  `SFCRC_ASSERT_NEXT(a_no_gap, out_valid && out_ready && !frame_end, out_valid && (byte_position == $past(byte_position) + 4'd1))

  // the next frame starts at position zero
  `SFCRC_ASSERT_NEXT(a_restart, out_valid && out_ready && frame_end, !out_valid || (byte_position == 4'd0))

endmodule

bind scope_frame_crc16_encoder sfcrc_checker #(
  .CHANNEL_COUNT (CHANNEL_COUNT)
) u_sfcrc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (frame.valid),
  .out_ready     (frame.ready),
  .frame_byte    (frame.frame_byte),
  .byte_position (frame.byte_position),
  .frame_end     (frame.frame_end)
);
